// File: rtl/core/ptc_pkg.sv
`default_nettype none
package ptc_pkg;

    localparam int DIV_W = 32;

    typedef enum logic [1:0] {
        ST_OK,
        ST_UNCAL,
        ST_OSS,
        ST_ZERO
    } status_t;

    typedef enum logic [2:0] {
        CFG_WORD_A,
        CFG_WORD_B,
        CFG_WORD_C,
        CFG_CAL_VALID
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] mc;
        logic [15:0] md;
    } coeff_t;

    typedef struct packed {
        logic [31:0] x1;
        logic [23:0] up;
        logic [1:0]  oss;
        status_t     status;
        logic        neg;
    } tpay_t;

    typedef struct packed {
        logic [31:0] t;
        status_t     status;
        logic        big;
    } ppay_t;

    localparam logic [31:0] C_T_OFS    = 32'd4000;
    localparam logic [31:0] C_P_3038   = 32'd3038;
    localparam logic [31:0] C_P_M7357  = 32'hFFFF_E343;
    localparam logic [31:0] C_P_3791   = 32'd3791;
    localparam logic [31:0] C_B7_SCALE = 32'd50000;
    localparam logic [31:0] C_X3_OFS   = 32'd32768;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sdiv_p2(input logic [31:0] a, input int k);
        logic [31:0] bias;
        logic [31:0] sum;
        bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
        sum  = a + bias;
        return 32'($signed(sum) >>> k);
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/ptc_udiv.sv
`default_nettype none
module ptc_udiv import ptc_pkg::*; #(
    parameter int PW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [31:0]   num,
    input  wire logic [31:0]   den,
    input  wire logic [PW-1:0] pay_in,
    output logic               out_valid,
    output logic [31:0]        quo,
    output logic [PW-1:0]      pay_out
);

    logic [DIV_W:0]   vld_reg;
    logic [DIV_W-1:0] rem_reg [0:DIV_W];
    logic [DIV_W-1:0] nq_reg  [0:DIV_W];
    logic [DIV_W-1:0] dv_reg  [0:DIV_W];
    logic [PW-1:0]    pay_reg [0:DIV_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_W-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            nq_reg[0]  <= num;
            dv_reg[0]  <= den;
            pay_reg[0] <= pay_in;
        end
    end

    for (genvar i = 0; i < DIV_W; i++)
    begin : g_step
        logic [DIV_W+1:0] diff;
        assign diff = {1'b0, rem_reg[i], nq_reg[i][DIV_W-1]} - {2'b00, dv_reg[i]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= diff[DIV_W+1] ? {rem_reg[i][DIV_W-2:0], nq_reg[i][DIV_W-1]}
                                              : diff[DIV_W-1:0];
                nq_reg[i+1]  <= {nq_reg[i][DIV_W-2:0], ~diff[DIV_W+1]};
                dv_reg[i+1]  <= dv_reg[i];
                pay_reg[i+1] <= pay_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[DIV_W];
    assign quo       = nq_reg[DIV_W];
    assign pay_out   = pay_reg[DIV_W];

endmodule
`default_nettype wire

// File: rtl/core/ptc_front.sv
`default_nettype none
module ptc_front import ptc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [15:0] raw_temperature,
    input  wire logic [23:0] raw_pressure,
    input  wire logic [2:0]  oversampling,
    input  wire logic        cal_valid,
    input  wire coeff_t      coeff,
    output logic             out_valid,
    output logic [31:0]      num,
    output logic [31:0]      den,
    output tpay_t            pay
);

    logic [3:0]  vld_reg;
    logic [31:0] d1_reg;
    logic [31:0] m1_reg;
    logic [31:0] x1_reg;
    logic [31:0] den_reg;
    logic [31:0] num_reg;
    logic [23:0] up1_reg, up2_reg, up3_reg;
    logic [1:0]  oss1_reg, oss2_reg, oss3_reg;
    status_t     st1_reg, st2_reg, st3_reg;
    tpay_t       pay_reg;
    logic [31:0] anum_reg, aden_reg;
    logic [23:0] up_next;
    status_t     st_next;
    logic [31:0] x1_next, den_next;

    always_comb
    begin
        case (oversampling[1:0])
            2'd0:    up_next = raw_pressure >> 8;
            2'd1:    up_next = raw_pressure >> 7;
            2'd2:    up_next = raw_pressure >> 6;
            default: up_next = raw_pressure >> 5;
        endcase
        if (!cal_valid)
        begin
            st_next = ST_UNCAL;
        end
        else if (oversampling[2])
        begin
            st_next = ST_OSS;
        end
        else
        begin
            st_next = ST_OK;
        end
        x1_next  = sdiv_p2(m1_reg, 15);
        den_next = x1_next + sext16(coeff.md);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg   <= {16'd0, raw_temperature} - {16'd0, coeff.ac6};
            up1_reg  <= up_next;
            oss1_reg <= oversampling[1:0];
            st1_reg  <= st_next;

            m1_reg   <= d1_reg * {16'd0, coeff.ac5};
            up2_reg  <= up1_reg;
            oss2_reg <= oss1_reg;
            st2_reg  <= st1_reg;

            x1_reg   <= x1_next;
            den_reg  <= den_next;
            num_reg  <= sext16(coeff.mc) << 11;
            up3_reg  <= up2_reg;
            oss3_reg <= oss2_reg;
            st3_reg  <= (st2_reg == ST_OK && den_next == 32'd0) ? ST_ZERO : st2_reg;

            anum_reg       <= num_reg[31] ? (32'd0 - num_reg) : num_reg;
            aden_reg       <= den_reg[31] ? (32'd0 - den_reg) : den_reg;
            pay_reg.x1     <= x1_reg;
            pay_reg.up     <= up3_reg;
            pay_reg.oss    <= oss3_reg;
            pay_reg.status <= st3_reg;
            pay_reg.neg    <= num_reg[31] ^ den_reg[31];
        end
    end

    assign out_valid = vld_reg[3];
    assign num       = anum_reg;
    assign den       = aden_reg;
    assign pay       = pay_reg;

endmodule
`default_nettype wire

// File: rtl/core/ptc_mid.sv
`default_nettype none
module ptc_mid import ptc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [31:0] quo,
    input  wire tpay_t       pay_in,
    input  wire coeff_t      coeff,
    output logic             out_valid,
    output logic [31:0]      num,
    output logic [31:0]      den,
    output ppay_t            pay
);

    localparam int NS = 11;

    logic [NS-1:0] vld_reg;
    status_t     st_reg [1:NS];
    logic [1:0]  oss_reg [1:9];
    logic [23:0] up_reg [1:8];
    logic [31:0] t_reg [2:NS];
    logic [31:0] b5_reg, b6_reg;
    logic [31:0] sqm_reg, a2m_reg, a3m_reg;
    logic [31:0] sq_reg, x2a_reg, x1c_reg;
    logic [31:0] b2sq_reg, b1sq_reg, x2a5_reg, x1c5_reg;
    logic [31:0] b3pre_reg, x3sum_reg;
    logic [31:0] b3m_reg, x3p_reg;
    logic [31:0] b3_reg, b4m_reg;
    logic [31:0] b4_reg, dup_reg;
    logic [31:0] b4d_reg, b7_reg;
    logic [31:0] num_reg, den_reg;
    logic        big_reg;
    logic [31:0] b4_next;

    assign b4_next = b4m_reg >> 15;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b5_reg     <= pay_in.x1 + (pay_in.neg ? (32'd0 - quo) : quo);
            st_reg[1]  <= pay_in.status;
            oss_reg[1] <= pay_in.oss;
            up_reg[1]  <= pay_in.up;

            t_reg[2]   <= sdiv_p2(b5_reg + 32'd8, 4);
            b6_reg     <= b5_reg - C_T_OFS;

            sqm_reg    <= b6_reg * b6_reg;
            a2m_reg    <= sext16(coeff.ac2) * b6_reg;
            a3m_reg    <= sext16(coeff.ac3) * b6_reg;

            sq_reg     <= sdiv_p2(sqm_reg, 12);
            x2a_reg    <= sdiv_p2(a2m_reg, 11);
            x1c_reg    <= sdiv_p2(a3m_reg, 13);

            b2sq_reg   <= sext16(coeff.b2) * sq_reg;
            b1sq_reg   <= sext16(coeff.b1) * sq_reg;
            x2a5_reg   <= x2a_reg;
            x1c5_reg   <= x1c_reg;

            b3pre_reg  <= (sext16(coeff.ac1) << 2) + sdiv_p2(b2sq_reg, 11) + x2a5_reg;
            x3sum_reg  <= x1c5_reg + sdiv_p2(b1sq_reg, 16) + 32'd2;

            b3m_reg    <= b3pre_reg << oss_reg[6];
            x3p_reg    <= sdiv_p2(x3sum_reg, 2) + C_X3_OFS;

            b3_reg     <= sdiv_p2(b3m_reg + 32'd2, 2);
            b4m_reg    <= {16'd0, coeff.ac4} * x3p_reg;

            b4_reg     <= b4_next;
            dup_reg    <= {8'd0, up_reg[8]} - b3_reg;

            b4d_reg    <= b4_reg;
            b7_reg     <= dup_reg * (C_B7_SCALE >> oss_reg[9]);

            num_reg    <= b7_reg[31] ? b7_reg : (b7_reg << 1);
            den_reg    <= b4d_reg;
            big_reg    <= b7_reg[31];

            for (int i = 2; i <= NS; i++)
            begin
                if (i == 9 && st_reg[8] == ST_OK && b4_next == 32'd0)
                begin
                    st_reg[i] <= ST_ZERO;
                end
                else
                begin
                    st_reg[i] <= st_reg[i-1];
                end
            end
            for (int i = 2; i <= 9; i++)
            begin
                oss_reg[i] <= oss_reg[i-1];
            end
            for (int i = 2; i <= 8; i++)
            begin
                up_reg[i] <= up_reg[i-1];
            end
            for (int i = 3; i <= NS; i++)
            begin
                t_reg[i] <= t_reg[i-1];
            end
        end
    end

    assign out_valid  = vld_reg[NS-1];
    assign num        = num_reg;
    assign den        = den_reg;
    assign pay.t      = t_reg[NS];
    assign pay.status = st_reg[NS];
    assign pay.big    = big_reg;

endmodule
`default_nettype wire

// File: rtl/core/ptc_tail.sv
`default_nettype none
module ptc_tail import ptc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [31:0] quo,
    input  wire ppay_t       pay_in,
    output logic             out_valid,
    output logic [31:0]      temperature,
    output logic [31:0]      pressure,
    output status_t          status
);

    localparam int NS = 6;

    logic [NS-1:0] vld_reg;
    status_t     st_reg [1:NS-1];
    logic [31:0] t_reg [1:NS-1];
    logic [31:0] p_reg [1:NS-1];
    logic [31:0] x1_reg, x2m_reg;
    logic [31:0] x1sq_reg, x2_reg;
    logic [31:0] x1m_reg, x2d_reg;
    logic [31:0] sum_reg;
    logic [31:0] tout_reg, pout_reg;
    status_t     sout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[1]  <= pay_in.big ? (quo << 1) : quo;
            t_reg[1]  <= pay_in.t;
            st_reg[1] <= pay_in.status;

            x1_reg    <= sdiv_p2(p_reg[1], 8);
            x2m_reg   <= p_reg[1] * C_P_M7357;

            x1sq_reg  <= x1_reg * x1_reg;
            x2_reg    <= sdiv_p2(x2m_reg, 16);

            x1m_reg   <= x1sq_reg * C_P_3038;
            x2d_reg   <= x2_reg;

            sum_reg   <= sdiv_p2(x1m_reg, 16) + x2d_reg + C_P_3791;

            for (int i = 2; i <= NS-1; i++)
            begin
                p_reg[i]  <= p_reg[i-1];
                t_reg[i]  <= t_reg[i-1];
                st_reg[i] <= st_reg[i-1];
            end

            sout_reg  <= st_reg[NS-1];
            if (st_reg[NS-1] == ST_OK)
            begin
                tout_reg <= t_reg[NS-1];
                pout_reg <= p_reg[NS-1] + sdiv_p2(sum_reg, 4);
            end
            else
            begin
                tout_reg <= '0;
                pout_reg <= '0;
            end
        end
    end

    assign out_valid   = vld_reg[NS-1];
    assign temperature = tout_reg;
    assign pressure    = pout_reg;
    assign status      = sout_reg;

endmodule
`default_nettype wire

// File: rtl/core/pressure_temperature_compensation.sv
// Compensates one raw temperature/pressure reading per beat into tenths of a
// degree Celsius and pascals, using the calibration words on the cfg port.
// Fully pipelined: a new beat enters every cycle while the result side is not
// stalled, through the two 32-stage restoring dividers (one quotient bit per
// stage) and the multiply and scaling stages around them. A stall on the
// result side holds every stage in place. Write the calibration words and
// then calibration_valid while the pipeline is empty; status 1, 2 or 3 forces
// both results to zero.
`default_nettype none
module pressure_temperature_compensation import ptc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // raw_temperature[15:0], raw_pressure[39:16], oversampling[42:40], zero pad
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // temperature[31:0], pressure[63:32], status[65:64], zero pad
    output logic [71:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [63:0] word_a_reg, word_b_reg;
    logic [31:0] word_c_reg;
    logic        cal_reg;
    coeff_t      coeff;
    logic        en;

    logic        f_valid;
    logic [31:0] f_num, f_den;
    tpay_t       f_pay;
    logic        d1_valid;
    logic [31:0] d1_quo;
    logic [$bits(tpay_t)-1:0] d1_pay;
    logic        m_valid;
    logic [31:0] m_num, m_den;
    ppay_t       m_pay;
    logic        d2_valid;
    logic [31:0] d2_quo;
    logic [$bits(ppay_t)-1:0] d2_pay;
    logic [31:0] t_out, p_out;
    status_t     s_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_a_reg <= '0;
            word_b_reg <= '0;
            word_c_reg <= '0;
            cal_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_WORD_A:    word_a_reg <= cfg_data;
                CFG_WORD_B:    word_b_reg <= cfg_data;
                CFG_WORD_C:    word_c_reg <= cfg_data[31:0];
                CFG_CAL_VALID: cal_reg    <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    assign coeff.ac1 = word_a_reg[63:48];
    assign coeff.ac2 = word_a_reg[47:32];
    assign coeff.ac3 = word_a_reg[31:16];
    assign coeff.ac4 = word_a_reg[15:0];
    assign coeff.ac5 = word_b_reg[63:48];
    assign coeff.ac6 = word_b_reg[47:32];
    assign coeff.b1  = word_b_reg[31:16];
    assign coeff.b2  = word_b_reg[15:0];
    assign coeff.mc  = word_c_reg[31:16];
    assign coeff.md  = word_c_reg[15:0];

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    ptc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (s_tvalid),
        .raw_temperature (s_tdata[15:0]),
        .raw_pressure    (s_tdata[39:16]),
        .oversampling    (s_tdata[42:40]),
        .cal_valid       (cal_reg),
        .coeff           (coeff),
        .out_valid       (f_valid),
        .num             (f_num),
        .den             (f_den),
        .pay             (f_pay)
    );

    ptc_udiv #(.PW($bits(tpay_t))) u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .num       (f_num),
        .den       (f_den),
        .pay_in    (f_pay),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .pay_out   (d1_pay)
    );

    ptc_mid u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d1_valid),
        .quo       (d1_quo),
        .pay_in    (tpay_t'(d1_pay)),
        .coeff     (coeff),
        .out_valid (m_valid),
        .num       (m_num),
        .den       (m_den),
        .pay       (m_pay)
    );

    ptc_udiv #(.PW($bits(ppay_t))) u_div_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_valid),
        .num       (m_num),
        .den       (m_den),
        .pay_in    (m_pay),
        .out_valid (d2_valid),
        .quo       (d2_quo),
        .pay_out   (d2_pay)
    );

    ptc_tail u_tail (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (d2_valid),
        .quo         (d2_quo),
        .pay_in      (ppay_t'(d2_pay)),
        .out_valid   (m_tvalid),
        .temperature (t_out),
        .pressure    (p_out),
        .status      (s_out)
    );

    assign m_tdata = {6'd0, s_out, p_out, t_out};

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[65:64] != ST_OK |-> m_tdata[63:0] == 64'd0)
        else $error("error status with nonzero result");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result beat changed during stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(d2_valid) && $stable(m_valid))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire
